[design/cme_pkg.sv]
// Shared constants, codes and types of the Condorcet minimax election unit.
`default_nettype none

package cme_pkg;

  localparam int MAX_CAND      = 8;
  localparam int CAND_BITS     = 3;
  localparam int PAIR_BITS     = 2 * CAND_BITS;
  localparam int PAIRS         = MAX_CAND * MAX_CAND;
  localparam int COUNT_BITS    = 16;
  localparam int SCORE_BITS    = 8;
  localparam int NCAND_BITS    = 4;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 4;
  localparam int IN_DATA_BITS  = 16;
  localparam int OUT_DATA_BITS = 24;

  localparam logic [NCAND_BITS-1:0] NCAND_RESET = NCAND_BITS'(MAX_CAND);

  localparam logic [CFG_IDX_BITS-1:0] CFG_NUM_CAND = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_MINMAX   = 2'd1;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_BALLOT = 2'd1,
    MODE_DECIDE = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW,
    ST_PAIR,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                  count_saturated;
    logic [COUNT_BITS-1:0] best_worst_wins;
    logic                  by_minmax;
    logic                  found;
    logic [CAND_BITS-1:0]  winner;
  } result_t;

endpackage

`default_nettype wire

[design/condorcet_minmax_election_unit.sv]
// Top level of the Condorcet minimax election unit: sequencer, win-count memory and result port.
//
// Channel | Direction | Handshake          | Payload
// in_     | slave     | in_tvalid/tready   | tdata: candidate, score; tuser: mode; tlast: last
// out_    | master    | out_tvalid/tready  | tdata: winner, found, by_minmax, best, saturated
// cfg_    | slave     | cfg_valid/ready    | cfg_index, cfg_data
//
// Clear, a plain ballot word and an unused mode are taken without leaving the idle state.
// A ballot's last word walks the n x n pairs through the one compare and increment unit.
// A decide walks the same pairs through the compare and minimum unit, and then waits
// if the previous result has not yet been taken from the output register.
// Reset is synchronous and clears the whole win-count table at once through valid bits.
`default_nettype none

module condorcet_minmax_election_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [2:0] candidate, [10:3] score, [15:11] zero
  input  logic [cme_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // [1:0] mode
  input  logic [1:0]                        in_tuser,
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] winner, [3] found, [4] by_minmax, [20:5] best_worst_wins,
  // [21] count_saturated, [23:22] zero
  output logic [cme_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cme_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [cme_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import cme_pkg::*;

  state_t                 state_r, state_nxt;
  logic [NCAND_BITS-1:0]  ncand_r;
  logic                   mm_en_r;
  logic [CAND_BITS-1:0]   n_last;

  logic                   in_fire;
  mode_t                  in_mode;
  logic [CAND_BITS-1:0]   in_cand;
  logic [SCORE_BITS-1:0]  in_score;

  logic [SCORE_BITS-1:0]  scores_r [MAX_CAND];
  logic [SCORE_BITS-1:0]  sa_r;
  logic [CAND_BITS-1:0]   a_r, b_r;
  logic                   op_close_r;

  logic [COUNT_BITS-1:0]  wins_mem [PAIRS];
  logic [PAIRS-1:0]       valid_r;
  logic [COUNT_BITS-1:0]  rd0_r, rd1_r;
  logic                   v0_r, v1_r;

  logic                   p_valid_r, p_skip_r, p_gt_r, p_rowend_r;
  logic [PAIR_BITS-1:0]   p_addr_r;
  logic [CAND_BITS-1:0]   p_row_r;

  logic [COUNT_BITS-1:0]  cur0, cur1, min_f;
  logic                   sat_hit, beats_f, mem_we;

  logic                   sat_r, beats_r, cw_found_r;
  logic [COUNT_BITS-1:0]  row_min_r, cw_best_r, mm_best_r;
  logic [CAND_BITS-1:0]   cw_idx_r, mm_idx_r;

  logic                   out_valid_r, out_load;
  result_t                out_res_r, res;
  logic                   mm_ok;

  assign in_fire  = in_tvalid & in_tready;
  assign in_mode  = mode_t'(in_tuser);
  assign in_cand  = in_tdata[CAND_BITS-1:0];
  assign in_score = in_tdata[CAND_BITS +: SCORE_BITS];

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_BITS'(out_res_r);

  always_comb begin
    if (ncand_r < NCAND_BITS'(2)) begin
      n_last = CAND_BITS'(1);
    end else if (ncand_r > NCAND_BITS'(MAX_CAND)) begin
      n_last = CAND_BITS'(MAX_CAND - 1);
    end else begin
      n_last = CAND_BITS'(ncand_r - NCAND_BITS'(1));
    end
  end

  assign cur0    = v0_r ? rd0_r : '0;
  assign cur1    = v1_r ? rd1_r : '0;
  assign sat_hit = (cur0 == '1);
  assign beats_f = beats_r & (p_skip_r | (cur0 > cur1));
  assign min_f   = (!p_skip_r && (cur0 < row_min_r)) ? cur0 : row_min_r;
  assign mem_we  = p_valid_r & op_close_r & ~p_skip_r & p_gt_r & ~sat_hit;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_fire) begin
          case (in_mode)
            MODE_BALLOT: if (in_tlast) state_nxt = ST_ROW;
            MODE_DECIDE: state_nxt = ST_ROW;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ROW: state_nxt = ST_PAIR;
      ST_PAIR: begin
        if (b_r == n_last) begin
          state_nxt = (a_r == n_last) ? ST_DRAIN : ST_ROW;
        end
      end
      ST_DRAIN: state_nxt = op_close_r ? ST_IDLE : ST_FINISH;
      ST_FINISH: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncand_r <= NCAND_RESET;
      mm_en_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NUM_CAND: ncand_r <= cfg_data;
        CFG_MINMAX:   mm_en_r <= cfg_data[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CAND; i++) scores_r[i] <= '0;
    end else if (in_fire && in_mode == MODE_CLEAR) begin
      for (int i = 0; i < MAX_CAND; i++) scores_r[i] <= '0;
    end else if (in_fire && in_mode == MODE_BALLOT) begin
      scores_r[in_cand] <= in_score;
    end else if (state_r == ST_DRAIN && op_close_r) begin
      for (int i = 0; i < MAX_CAND; i++) scores_r[i] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r        <= '0;
      b_r        <= '0;
      op_close_r <= 1'b0;
      p_valid_r  <= 1'b0;
    end else begin
      p_valid_r <= (state_r == ST_PAIR);
      if (in_fire) begin
        a_r        <= '0;
        b_r        <= '0;
        op_close_r <= (in_mode == MODE_BALLOT);
      end else if (state_r == ST_PAIR) begin
        if (b_r == n_last) begin
          b_r <= '0;
          a_r <= a_r + CAND_BITS'(1);
        end else begin
          b_r <= b_r + CAND_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ROW) begin
      sa_r <= scores_r[a_r];
    end
    if (state_r == ST_PAIR) begin
      p_addr_r   <= {a_r, b_r};
      p_skip_r   <= (a_r == b_r);
      p_gt_r     <= (sa_r > scores_r[b_r]);
      p_rowend_r <= (b_r == n_last);
      p_row_r    <= a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wins_mem[p_addr_r] <= cur0 + COUNT_BITS'(1);
    end
    rd0_r <= wins_mem[{a_r, b_r}];
    rd1_r <= wins_mem[{b_r, a_r}];
    v0_r  <= valid_r[{a_r, b_r}];
    v1_r  <= valid_r[{b_r, a_r}];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (in_fire && in_mode == MODE_CLEAR) begin
      valid_r <= '0;
    end else if (mem_we) begin
      valid_r[p_addr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r      <= 1'b0;
      beats_r    <= 1'b1;
      row_min_r  <= '1;
      cw_found_r <= 1'b0;
      cw_idx_r   <= '0;
      cw_best_r  <= '0;
      mm_best_r  <= '0;
      mm_idx_r   <= '0;
    end else if (in_fire && in_mode == MODE_CLEAR) begin
      sat_r <= 1'b0;
    end else if (in_fire && in_mode == MODE_DECIDE) begin
      beats_r    <= 1'b1;
      row_min_r  <= '1;
      cw_found_r <= 1'b0;
      mm_best_r  <= '0;
      mm_idx_r   <= '0;
    end else if (p_valid_r) begin
      if (op_close_r) begin
        if (!p_skip_r && p_gt_r && sat_hit) sat_r <= 1'b1;
      end else if (p_rowend_r) begin
        beats_r   <= 1'b1;
        row_min_r <= '1;
        if (beats_f && !cw_found_r) begin
          cw_found_r <= 1'b1;
          cw_idx_r   <= p_row_r;
          cw_best_r  <= min_f;
        end
        if (min_f > mm_best_r) begin
          mm_best_r <= min_f;
          mm_idx_r  <= p_row_r;
        end
      end else begin
        beats_r   <= beats_f;
        row_min_r <= min_f;
      end
    end
  end

  assign mm_ok = mm_en_r && (mm_best_r != '0);

  always_comb begin
    res                 = '0;
    res.count_saturated = sat_r;
    if (cw_found_r) begin
      res.found           = 1'b1;
      res.winner          = cw_idx_r;
      res.best_worst_wins = cw_best_r;
    end else if (mm_ok) begin
      res.found           = 1'b1;
      res.by_minmax       = 1'b1;
      res.winner          = mm_idx_r;
      res.best_worst_wins = mm_best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res_r <= res;
    end
  end

  a_no_pair_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !p_valid_r)
    else $error("pair stage busy while idle");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.found |->
      out_res_r.winner == '0 && out_res_r.best_worst_wins == '0 && !out_res_r.by_minmax)
    else $error("result without winner carries nonzero fields");

  a_decide_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_mode == MODE_DECIDE |=> state_r == ST_ROW)
    else $error("decide did not start the matrix walk");

  a_sat_cleared_only: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(sat_r) |-> $past(in_fire && in_mode == MODE_CLEAR))
    else $error("saturation flag dropped without a clear");

  a_no_diag_write: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> p_addr_r[PAIR_BITS-1:CAND_BITS] != p_addr_r[CAND_BITS-1:0])
    else $error("win count written on the diagonal");

endmodule

`default_nettype wire
